// ----- rtl/spm_pkg.sv -----
// ============================================================================
// spm_pkg
// Shared types, constants and tables of the SSB polar modulator.
// ============================================================================
`default_nettype none

package spm_pkg;

  localparam int TAPS   = 45;
  localparam int ADDR_W = 6;
  localparam int NWTS   = 11;

  localparam logic [15:0] CFG_RATE_RST    = 16'd8000;
  localparam logic [27:0] CFG_CARRIER_RST = 28'd7200000;

  localparam logic [7:0] REG_SAMPLE_RATE = 8'd0;
  localparam logic [7:0] REG_CARRIER_HZ  = 8'd1;

  localparam logic [15:0] AMP_FULL = 16'd32768;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MCALC,
    S_VWR,
    S_QINIT,
    S_QRD,
    S_QACC,
    S_IRD,
    S_IGET,
    S_PREP,
    S_AWT,
    S_SQGO,
    S_SQWT,
    S_OFFP,
    S_OFFC,
    S_DONE
  } state_t;

  typedef struct packed {
    logic take;
    logic m_get;
    logic v_wr;
    logic q_clr;
    logic q_rd;
    logic q_acc;
    logic i_rd;
    logic i_get;
    logic q_get;
    logic prep;
    logic div_go;
    logic ph_get;
    logic sq_go;
    logic amp_get;
    logic off_prep;
    logic off_get;
    logic out_load;
  } spm_cmd_t;

  typedef struct packed {
    logic div_done;
    logic sq_done;
    logic last_tap;
  } spm_sts_t;

  // Hilbert weights for odd taps, innermost last
  function automatic logic [6:0] hilbert_w(input logic [3:0] k);
    logic [6:0] w;
    case (k)
      4'd0:    w = 7'd1;
      4'd1:    w = 7'd1;
      4'd2:    w = 7'd1;
      4'd3:    w = 7'd2;
      4'd4:    w = 7'd4;
      4'd5:    w = 7'd6;
      4'd6:    w = 7'd9;
      4'd7:    w = 7'd14;
      4'd8:    w = 7'd23;
      4'd9:    w = 7'd41;
      4'd10:   w = 7'd127;
      default: w = 7'd0;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/spm_div.sv -----
// ============================================================================
// spm_div
// Restoring unsigned divider, 32-bit dividend by 16-bit divisor, one
// quotient bit per cycle. Quotient holds until the next start.
// ============================================================================
`default_nettype none

module spm_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [15:0] divisor,
  output logic             done,
  output logic [31:0]      quotient
);

  logic [31:0] quo_r, quo_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [15:0] dvs_r;
  logic [5:0]  cnt_r;
  logic        busy_r, done_r;
  logic [16:0] rem_sh;
  logic        ge;

  always_comb begin
    rem_sh  = {rem_r, quo_r[31]};
    ge      = rem_sh >= {1'b0, dvs_r};
    rem_nxt = ge ? 16'(rem_sh - {1'b0, dvs_r}) : rem_sh[15:0];
    quo_nxt = {quo_r[30:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// ----- rtl/spm_isqrt.sv -----
// ============================================================================
// spm_isqrt
// Digit-by-digit integer square root of (sum << 16), two radicand bits per
// cycle.
// ============================================================================
`default_nettype none

module spm_isqrt (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [17:0] sum,
  output logic             done,
  output logic [17:0]      root
);

  logic [35:0] rad_r;
  logic [19:0] rem_r, rem_nxt, rem_sh, trial;
  logic [17:0] root_r, root_nxt;
  logic [4:0]  cnt_r;
  logic        busy_r, done_r, ge;

  always_comb begin
    rem_sh   = {rem_r[17:0], rad_r[35:34]};
    trial    = {root_r, 2'b01};
    ge       = rem_sh >= trial;
    rem_nxt  = ge ? rem_sh - trial : rem_sh;
    root_nxt = {root_r[16:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd17) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= {2'b00, sum, 16'h0000};
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[33:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

`default_nettype wire

// ----- rtl/spm_dp.sv -----
// ============================================================================
// spm_dp
// Datapath: config registers, 45-entry delay line in a circular buffer,
// Hilbert accumulator, arctangent divider, square root and output registers.
// ============================================================================
`default_nettype none

module spm_dp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire spm_pkg::spm_cmd_t cmd,
  output spm_pkg::spm_sts_t      sts,
  input  wire logic [11:0]       in_adc_sample,
  input  wire logic              cfg_we,
  input  wire logic [7:0]        cfg_index,
  input  wire logic [31:0]       cfg_data,
  output logic [15:0]            out_amplitude,
  output logic [8:0]             out_phase_deg,
  output logic [19:0]            out_freq_offset,
  output logic [31:0]            out_tx_freq
);

  // config
  logic [15:0] rate_r;
  logic [27:0] carrier_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r    <= spm_pkg::CFG_RATE_RST;
      carrier_r <= spm_pkg::CFG_CARRIER_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        spm_pkg::REG_SAMPLE_RATE: rate_r    <= cfg_data[15:0];
        spm_pkg::REG_CARRIER_HZ:  carrier_r <= cfg_data[27:0];
        default: ;
      endcase
    end
  end

  logic [11:0] sample_r;
  always_ff @(posedge clk) begin
    if (cmd.take) sample_r <= in_adc_sample;
  end

  // sample scaling: m = 16*s + s/273 (s*3841 >> 20 is exact for 12 bits),
  // v = m*128/32767 as (m >> 8) plus one correction step
  logic [23:0] s_prod;
  logic [15:0] m_r;
  logic [15:0] v_rem;
  logic [8:0]  v_val;

  assign s_prod = sample_r * 12'd3841;

  always_ff @(posedge clk) begin
    if (cmd.m_get) m_r <= {sample_r, 4'd0} + {12'd0, s_prod[23:20]};
  end

  assign v_rem = {8'd0, m_r[15:8]} + {1'b0, m_r[7:0], 7'd0};
  assign v_val = {1'b0, m_r[15:8]} + {8'd0, (v_rem >= 16'd32767)};

  // arctangent divider
  logic        div_done;
  logic [31:0] div_q;
  logic [31:0] div_a;
  logic [15:0] div_b;
  logic [17:0] acc_abs;
  logic [13:0] atan_num;
  logic [9:0]  atan_den;
  logic [24:0] prod_r;

  assign div_a = {18'd0, atan_num};
  assign div_b = {6'd0, atan_den};

  spm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_go),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  // delay line: wp_r points at the oldest entry (logical tap 0)
  logic [8:0]                 mem [spm_pkg::TAPS];
  logic [spm_pkg::TAPS-1:0]   valid_r;
  logic [spm_pkg::ADDR_W-1:0] wp_r, ra_r, rb_r, addr_a, i_addr;
  logic [8:0]                 da_r, db_r;

  function automatic logic [spm_pkg::ADDR_W-1:0] add_mod(
    input logic [spm_pkg::ADDR_W-1:0] a, input logic [spm_pkg::ADDR_W-1:0] b);
    logic [spm_pkg::ADDR_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (spm_pkg::ADDR_W+1)'(spm_pkg::TAPS))
      s = s - (spm_pkg::ADDR_W+1)'(spm_pkg::TAPS);
    return s[spm_pkg::ADDR_W-1:0];
  endfunction

  assign i_addr = add_mod(wp_r, spm_pkg::ADDR_W'(22));
  assign addr_a = cmd.i_rd ? i_addr : ra_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      wp_r    <= '0;
    end else if (cmd.v_wr) begin
      valid_r[wp_r] <= 1'b1;
      wp_r          <= add_mod(wp_r, spm_pkg::ADDR_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.v_wr) mem[wp_r] <= v_val;
    if (cmd.q_rd || cmd.i_rd) begin
      da_r <= valid_r[addr_a] ? mem[addr_a] : 9'd0;
      db_r <= valid_r[rb_r] ? mem[rb_r] : 9'd0;
    end
  end

  // Hilbert accumulation: tap 1+2k minus tap 43-2k
  logic        [3:0]  k_r;
  logic signed [17:0] acc_r;
  logic signed [9:0]  tap_diff;
  logic signed [17:0] term;
  logic        [31:0] q_prod;

  assign tap_diff = $signed({1'b0, da_r}) - $signed({1'b0, db_r});
  assign term     = 18'($signed({1'b0, spm_pkg::hilbert_w(k_r)}) * tap_diff);
  assign acc_abs  = acc_r[17] ? 18'(-acc_r) : acc_r;
  // |sum| stays below 2^16; *41528 >> 23 divides by 202 exactly there
  assign q_prod   = acc_abs[15:0] * 16'd41528;

  always_ff @(posedge clk) begin
    if (cmd.q_clr) begin
      acc_r <= '0;
      k_r   <= '0;
      ra_r  <= add_mod(wp_r, spm_pkg::ADDR_W'(1));
      rb_r  <= add_mod(wp_r, spm_pkg::ADDR_W'(43));
    end else if (cmd.q_acc) begin
      acc_r <= acc_r + term;
      k_r   <= k_r + 4'd1;
      ra_r  <= add_mod(ra_r, spm_pkg::ADDR_W'(2));
      rb_r  <= add_mod(rb_r, spm_pkg::ADDR_W'(43));
    end
  end

  // I, Q, arctangent; I is never negative so only the x >= 0 branch applies
  logic [8:0]        i_r, qabs_r;
  logic [16:0]       isq_r;
  logic              q_neg_r, a_neg_r;
  logic [17:0]       sum_r;
  logic signed [9:0] ad;
  logic [8:0]        ad_abs;
  logic [9:0]        den_raw;
  logic [6:0]        a_ang;
  logic [8:0]        phase_r, prev_r;

  assign den_raw  = {1'b0, i_r} + {1'b0, qabs_r};
  assign atan_den = (den_raw == 10'd0) ? 10'd1 : den_raw;
  assign ad       = $signed({1'b0, i_r}) - $signed({1'b0, qabs_r});
  assign ad_abs   = ad[9] ? 9'(-ad) : ad[8:0];
  assign atan_num = 14'(ad_abs * 6'd45);
  assign a_ang    = a_neg_r ? 7'(7'd45 + {1'b0, div_q[5:0]})
                            : 7'(7'd45 - {1'b0, div_q[5:0]});

  always_ff @(posedge clk) begin
    if (cmd.i_get) begin
      i_r     <= da_r;
      isq_r   <= 17'(da_r * da_r);
      q_neg_r <= acc_r[17];
    end
    if (cmd.q_get) qabs_r <= q_prod[31:23];
    if (cmd.prep) begin
      sum_r   <= {1'b0, isq_r} + 18'(qabs_r * qabs_r);
      a_neg_r <= ad[9];
    end
    // a negative sum that truncates to zero counts as Q = 0
    if (cmd.ph_get)
      phase_r <= (q_neg_r && (qabs_r != 9'd0)) ? 9'(9'd180 - {2'b0, a_ang})
                                               : 9'(9'd180 + {2'b0, a_ang});
  end

  // envelope
  logic        sq_done;
  logic [17:0] root;
  logic [15:0] amp_r;

  spm_isqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.sq_go),
    .sum   (sum_r),
    .done  (sq_done),
    .root  (root)
  );

  always_ff @(posedge clk) begin
    if (cmd.amp_get)
      amp_r <= (root > {2'b0, spm_pkg::AMP_FULL}) ? spm_pkg::AMP_FULL : root[15:0];
  end

  // phase step and frequency offset
  logic [8:0]  dph;
  logic [19:0] off_r;
  logic [51:0] off_prod;

  assign dph = (phase_r >= prev_r) ? 9'(phase_r - prev_r)
                                   : 9'(phase_r + 9'd360 - prev_r);

  // prod*16/360 = (2*prod)/45; *47721859 >> 31 is exact below 2^26
  assign off_prod = {prod_r, 1'b0} * 26'd47721859;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else if (cmd.off_prep) begin
      prev_r <= phase_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.off_prep) prod_r <= 25'(dph * rate_r);
    if (cmd.off_get)  off_r  <= off_prod[50:31];
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_amplitude   <= amp_r;
      out_phase_deg   <= phase_r;
      out_freq_offset <= off_r;
      out_tx_freq     <= {carrier_r, 4'd0} + {12'd0, off_r};
    end
  end

  assign sts.div_done = div_done;
  assign sts.sq_done  = sq_done;
  assign sts.last_tap = (k_r == 4'(spm_pkg::NWTS - 1));

endmodule

`default_nettype wire

// ----- rtl/spm_ctrl.sv -----
// ============================================================================
// spm_ctrl
// Sequencer: steps one sample through the datapath and owns the handshakes.
// ============================================================================
`default_nettype none

module spm_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  input  wire spm_pkg::spm_sts_t sts,
  output spm_pkg::spm_cmd_t     cmd
);

  spm_pkg::state_t state_r, state_nxt;
  logic            out_valid_r;
  logic            out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      spm_pkg::S_IDLE:  if (in_valid) state_nxt = spm_pkg::S_MCALC;
      spm_pkg::S_MCALC: state_nxt = spm_pkg::S_VWR;
      spm_pkg::S_VWR:   state_nxt = spm_pkg::S_QINIT;
      spm_pkg::S_QINIT: state_nxt = spm_pkg::S_QRD;
      spm_pkg::S_QRD:   state_nxt = spm_pkg::S_QACC;
      spm_pkg::S_QACC:  state_nxt = sts.last_tap ? spm_pkg::S_IRD : spm_pkg::S_QRD;
      spm_pkg::S_IRD:   state_nxt = spm_pkg::S_IGET;
      spm_pkg::S_IGET:  state_nxt = spm_pkg::S_PREP;
      spm_pkg::S_PREP:  state_nxt = spm_pkg::S_AWT;
      spm_pkg::S_AWT:   if (sts.div_done) state_nxt = spm_pkg::S_SQGO;
      spm_pkg::S_SQGO:  state_nxt = spm_pkg::S_SQWT;
      spm_pkg::S_SQWT:  if (sts.sq_done) state_nxt = spm_pkg::S_OFFP;
      spm_pkg::S_OFFP:  state_nxt = spm_pkg::S_OFFC;
      spm_pkg::S_OFFC:  state_nxt = spm_pkg::S_DONE;
      spm_pkg::S_DONE:  if (out_free) state_nxt = spm_pkg::S_IDLE;
      default:          state_nxt = spm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      spm_pkg::S_IDLE:  cmd.take = in_valid;
      spm_pkg::S_MCALC: cmd.m_get = 1'b1;
      spm_pkg::S_VWR:   cmd.v_wr = 1'b1;
      spm_pkg::S_QINIT: cmd.q_clr = 1'b1;
      spm_pkg::S_QRD:   cmd.q_rd = 1'b1;
      spm_pkg::S_QACC:  cmd.q_acc = 1'b1;
      spm_pkg::S_IRD:   cmd.i_rd = 1'b1;
      spm_pkg::S_IGET: begin
        cmd.i_get = 1'b1;
        cmd.q_get = 1'b1;
      end
      spm_pkg::S_PREP: begin
        cmd.prep   = 1'b1;
        cmd.div_go = 1'b1;
      end
      spm_pkg::S_AWT:   cmd.ph_get = sts.div_done;
      spm_pkg::S_SQGO:  cmd.sq_go = 1'b1;
      spm_pkg::S_SQWT:  cmd.amp_get = sts.sq_done;
      spm_pkg::S_OFFP:  cmd.off_prep = 1'b1;
      spm_pkg::S_OFFC:  cmd.off_get = 1'b1;
      spm_pkg::S_DONE:  cmd.out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= spm_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.out_load)
        out_valid_r <= 1'b1;
      else if (out_ready)
        out_valid_r <= 1'b0;
    end
  end

  assign in_ready  = (state_r == spm_pkg::S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ----- rtl/ssb_polar_modulator.sv -----
// Flow: each input beat passes through scaling, the Hilbert sum, the arctangent
//   divide, the square root and the frequency offset step before the result is valid.
// Input: one sample at a time; the next input beat is taken once the
//   result has moved into the output register, so a held result stalls input.
// Reset: synchronous, active low; delay line reads zero, previous phase zero,
//   sample_rate 8000 and carrier_hz 7200000.
// ============================================================================
// ssb_polar_modulator
// Hilbert-transform SSB polar modulator: envelope, phase and transmit
// frequency per microphone sample.
// ============================================================================
`default_nettype none

module ssb_polar_modulator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [11:0] in_adc_sample,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_amplitude,
  output logic [8:0]       out_phase_deg,
  output logic [19:0]      out_freq_offset,
  output logic [31:0]      out_tx_freq,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  spm_pkg::spm_cmd_t cmd;
  spm_pkg::spm_sts_t sts;

  assign cfg_ready = 1'b1;

  spm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  spm_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_adc_sample   (in_adc_sample),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_amplitude   (out_amplitude),
    .out_phase_deg   (out_phase_deg),
    .out_freq_offset (out_freq_offset),
    .out_tx_freq     (out_tx_freq)
  );

`ifndef SYNTHESIS
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while busy");

  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(sts.div_done && sts.sq_done))
    else $error("divider and square root finished together");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_phase_deg <= 9'd360))
    else $error("phase out of range");

  a_amp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_amplitude <= spm_pkg::AMP_FULL))
    else $error("amplitude not saturated");
`endif

endmodule

`default_nettype wire
